/* hdl/abra_pkg.sv */
// Shared types, constants and a helper function for the admin block region allocator.
// No dependencies; imported by abra_cell and admin_block_region_allocator.
`default_nettype none

package abra_pkg;

    localparam int REGIONS_DEF   = 64;
    localparam int REGION_BLOCKS = 32;
    localparam logic [31:0] TOP_BIT = 32'h8000_0000;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_TABLE_FULL = 2'd2
    } status_t;

    // Request token that travels down the row of cells, one cell per cycle.
    typedef struct packed {
        logic        active;
        logic        kind;
        logic        served;
        logic [31:0] block;
        logic [31:0] spare;
        logic [31:0] result_block;
        logic        took_spare;
    } token_t;

    // Offset of the first zero bit counting down from bit 31; map must hold a zero.
    function automatic logic [4:0] first_zero_from_top(input logic [31:0] map);
        logic [4:0] off;
        off = '0;
        for (int i = 0; i < REGION_BLOCKS; i++) begin
            if (!map[i]) begin
                off = 5'(31 - i);
            end
        end
        return off;
    endfunction

endpackage

`default_nettype wire

/* hdl/admin_block_region_allocator.sv */
// Admin block region allocator: a row of REGIONS cells, one region each.
// A request is registered at the input, passes each cell's token register
// in turn, and its result is registered at the output. Only one request is
// in flight; the next is taken after the result transfer.
// Reset clears all slot valid bits and the handshake state; region base and
// use map contents stay undefined until a slot is installed.
`default_nettype none

module admin_block_region_allocator #(
    parameter int REGIONS = abra_pkg::REGIONS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [31:0] block, [63:32] spare_region
    input  wire  [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata    // [1:0] status, [33:2] allocated_block,
                                   // [34] took_spare, [39:35] zero
);
    import abra_pkg::*;

    token_t tok [REGIONS+1];

    logic   busy_reg, busy_next;
    token_t in_tok_reg, in_tok_next;
    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg, out_data_next;

    logic    s_accept;
    logic    m_accept;
    token_t  last_tok;
    status_t res_status;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;
    assign s_tready = !busy_reg;

    always_comb begin
        in_tok_next              = in_tok_reg;
        in_tok_next.active       = s_accept;
        if (s_accept) begin
            in_tok_next.kind         = s_tuser[0];
            in_tok_next.served       = 1'b0;
            in_tok_next.block        = s_tdata[31:0];
            in_tok_next.spare        = s_tdata[63:32];
            in_tok_next.result_block = '0;
            in_tok_next.took_spare   = 1'b0;
        end
    end

    assign tok[0] = in_tok_reg;

    for (genvar g = 0; g < REGIONS; g++) begin : g_cell
        abra_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
    end

    assign last_tok = tok[REGIONS];

    always_comb begin
        if (last_tok.served) begin
            res_status = ST_OK;
        end else if (last_tok.kind == KIND_ALLOC) begin
            res_status = ST_TABLE_FULL;
        end else begin
            res_status = ST_NOT_FOUND;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        busy_next      = busy_reg;
        if (m_accept) begin
            out_valid_next = 1'b0;
            busy_next      = 1'b0;
        end
        if (s_accept) begin
            busy_next = 1'b1;
        end
        if (last_tok.active) begin
            out_valid_next = 1'b1;
            out_data_next  = {5'd0, last_tok.took_spare, last_tok.result_block,
                              res_status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
            in_tok_reg.active <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            in_tok_reg    <= in_tok_next;
        end
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* hdl/abra_cell.sv */
// One region slot of the allocator chain: base, use map and valid bit.
// Depends on abra_pkg for the token type and helper function.
`default_nettype none

module abra_cell (
    input  wire               aclk,
    input  wire               aresetn,
    input  abra_pkg::token_t  tok_in,
    output abra_pkg::token_t  tok_out
);
    import abra_pkg::*;

    logic        valid_reg, valid_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] map_reg, map_next;
    token_t      tok_reg, tok_next;

    logic [4:0]  zero_off;
    logic        has_zero;
    logic [31:0] diff;
    logic        hit;
    logic        take;
    logic        alloc_here;
    logic        free_here;

    always_comb begin
        zero_off = first_zero_from_top(map_reg);
        has_zero = ~&map_reg;
        diff     = tok_in.block - base_reg;
        hit      = (diff[31:5] == '0);
        take     = tok_in.active && !tok_in.served;
        // Valid slots always form a prefix, so the first invalid slot reached
        // is the lowest free one and every valid region has been scanned.
        alloc_here = take && (tok_in.kind == KIND_ALLOC) && (!valid_reg || has_zero);
        free_here  = take && (tok_in.kind == KIND_FREE) && valid_reg && hit;
    end

    always_comb begin
        valid_next = valid_reg;
        base_next  = base_reg;
        map_next   = map_reg;
        tok_next   = tok_in;
        if (alloc_here) begin
            tok_next.served = 1'b1;
            if (valid_reg) begin
                map_next              = map_reg | (TOP_BIT >> zero_off);
                tok_next.result_block = base_reg + {27'd0, zero_off};
            end else begin
                valid_next            = 1'b1;
                base_next             = tok_in.spare;
                map_next              = TOP_BIT;
                tok_next.result_block = tok_in.spare;
                tok_next.took_spare   = 1'b1;
            end
        end else if (free_here) begin
            tok_next.served = 1'b1;
            map_next        = map_reg & ~(TOP_BIT >> diff[4:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            tok_reg.active <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
        base_reg <= base_next;
        map_reg  <= map_next;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
